[rtl/prmv_pkg.sv]
package prmv_pkg;

	localparam int PIX_W  = 16;
	localparam int MEAN_W = 24;
	localparam int S_W    = 56;
	localparam int VAR_W  = 48;
	localparam int SUM_W  = 64;
	localparam int CNT_W  = 32;
	localparam int FC_W   = 16;
	localparam int WU_W   = 4;
	localparam int NUM_W  = 64;
	localparam int DEN_W  = 32;
	localparam int PROD_W = 48;

	localparam logic [WU_W-1:0]   WARMUP_RESET = 4'd2;
	localparam logic [MEAN_W-1:0] MEAN_LIMIT   = '1;
	localparam logic [VAR_W-1:0]  VAR_LIMIT    = '1;
	localparam logic [S_W-1:0]    S_LIMIT      = '1;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CHECK, ST_READ, ST_STEP_GO, ST_STEP_WAIT, ST_MEAN, ST_PROD,
		ST_SADD, ST_VAR_GO, ST_VAR_WAIT, ST_WRITE, ST_AVGM_GO, ST_AVGM_WAIT,
		ST_AVGV_GO, ST_AVGV_WAIT, ST_SQA_GO, ST_SQA_WAIT, ST_SQN_GO, ST_SQN_WAIT,
		ST_SQX_GO, ST_SQX_WAIT, ST_SEND
	} state_t;

	typedef enum logic [2:0] {
		OP_STEP, OP_VAR, OP_AVGM, OP_AVGV, OP_SQA, OP_SQN, OP_SQX
	} op_t;

	typedef struct packed {
		logic take;
		logic grab;
		logic check;
		logic rd;
		logic div_start;
		logic sqrt_start;
		op_t  op;
		logic cap;
		logic ld_mean;
		logic ld_prod;
		logic ld_sadd;
		logic write;
		logic send;
	} ctrl_cmd_t;

	typedef struct packed {
		logic skip;
		logic first;
		logic last;
		logic div_done;
		logic sqrt_done;
		logic out_free;
	} ctrl_sts_t;

endpackage

[rtl/prmv_pix_if.sv]
interface prmv_pix_if;
	import prmv_pkg::*;

	logic             valid;
	logic             ready;
	logic             kind;
	logic [PIX_W-1:0] pixel;
	logic             last_in_frame;

	modport source (output valid, kind, pixel, last_in_frame, input ready);
	modport sink (input valid, kind, pixel, last_in_frame, output ready);
endinterface

[rtl/prmv_res_if.sv]
interface prmv_res_if;
	import prmv_pkg::*;

	logic              valid;
	logic              ready;
	logic [FC_W-1:0]   frames_used;
	logic [PIX_W-1:0]  capture_min;
	logic [PIX_W-1:0]  capture_max;
	logic [MEAN_W-1:0] mean_average;
	logic [MEAN_W-1:0] mean_min;
	logic [MEAN_W-1:0] mean_max;
	logic [MEAN_W-1:0] std_of_average_variance;
	logic [MEAN_W-1:0] std_min;
	logic [MEAN_W-1:0] std_max;

	modport source (output valid, frames_used, capture_min, capture_max, mean_average,
		mean_min, mean_max, std_of_average_variance, std_min, std_max, input ready);
	modport sink (input valid, frames_used, capture_min, capture_max, mean_average,
		mean_min, mean_max, std_of_average_variance, std_min, std_max, output ready);
endinterface

[rtl/prmv_ram.sv]
module prmv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/prmv_div.sv]
module prmv_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [prmv_pkg::NUM_W-1:0] num,
	input  logic [prmv_pkg::DEN_W-1:0] den,
	output logic [prmv_pkg::NUM_W-1:0] quo,
	output logic [prmv_pkg::DEN_W-1:0] rem,
	output logic                     done
);
	import prmv_pkg::*;

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [6:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic             fits;

	// One quotient bit per cycle, restoring form.
	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
		end
	end

	assign quo  = quo_q;
	assign rem  = rem_q;
	assign done = done_q;
endmodule

[rtl/prmv_sqrt.sv]
module prmv_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [prmv_pkg::VAR_W-1:0]  value,
	output logic [prmv_pkg::MEAN_W-1:0] root,
	output logic [prmv_pkg::MEAN_W+1:0] rem,
	output logic                      done
);
	import prmv_pkg::*;

	logic [VAR_W-1:0]  v_q;
	logic [MEAN_W-1:0] root_q;
	logic [MEAN_W+1:0] rem_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [MEAN_W+3:0] rem_sh;
	logic [MEAN_W+3:0] trial;
	logic              fits;

	// Two radicand bits enter per cycle; rem ends as value - root*root.
	assign rem_sh = {rem_q, v_q[VAR_W-1:VAR_W-2]};
	assign trial  = (MEAN_W+4)'({root_q, 2'b01});
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(MEAN_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= value;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			v_q    <= {v_q[VAR_W-3:0], 2'b00};
			root_q <= {root_q[MEAN_W-2:0], fits};
			rem_q  <= fits ? (MEAN_W+2)'(rem_sh - trial) : rem_sh[MEAN_W+1:0];
		end
	end

	assign root = root_q;
	assign rem  = rem_q;
	assign done = done_q;
endmodule

[rtl/prmv_ctrl.sv]
module prmv_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  prmv_pkg::ctrl_sts_t sts,
	output prmv_pkg::ctrl_cmd_t cmd
);
	import prmv_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (in_valid) state_d = ST_CHECK;
			ST_CHECK:     state_d = sts.skip ? ST_IDLE : ST_READ;
			ST_READ:      state_d = sts.first ? ST_WRITE : ST_STEP_GO;
			ST_STEP_GO:   state_d = ST_STEP_WAIT;
			ST_STEP_WAIT: if (sts.div_done) state_d = ST_MEAN;
			ST_MEAN:      state_d = ST_PROD;
			ST_PROD:      state_d = ST_SADD;
			ST_SADD:      state_d = ST_VAR_GO;
			ST_VAR_GO:    state_d = ST_VAR_WAIT;
			ST_VAR_WAIT:  if (sts.div_done) state_d = ST_WRITE;
			ST_WRITE:     state_d = sts.last ? ST_AVGM_GO : ST_IDLE;
			ST_AVGM_GO:   state_d = ST_AVGM_WAIT;
			ST_AVGM_WAIT: if (sts.div_done) state_d = ST_AVGV_GO;
			ST_AVGV_GO:   state_d = ST_AVGV_WAIT;
			ST_AVGV_WAIT: if (sts.div_done) state_d = ST_SQA_GO;
			ST_SQA_GO:    state_d = ST_SQA_WAIT;
			ST_SQA_WAIT:  if (sts.sqrt_done) state_d = ST_SQN_GO;
			ST_SQN_GO:    state_d = ST_SQN_WAIT;
			ST_SQN_WAIT:  if (sts.sqrt_done) state_d = ST_SQX_GO;
			ST_SQX_GO:    state_d = ST_SQX_WAIT;
			ST_SQX_WAIT:  if (sts.sqrt_done) state_d = ST_SEND;
			ST_SEND:      if (sts.out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.op = OP_STEP;
		unique case (state_q)
			ST_IDLE: begin
				cmd.take = 1'b1;
				cmd.grab = in_valid;
			end
			ST_CHECK:     cmd.check = 1'b1;
			ST_READ:      cmd.rd = 1'b1;
			ST_STEP_GO:   cmd.div_start = 1'b1;
			ST_STEP_WAIT: cmd.op = OP_STEP;
			ST_MEAN:      cmd.ld_mean = 1'b1;
			ST_PROD:      cmd.ld_prod = 1'b1;
			ST_SADD:      cmd.ld_sadd = 1'b1;
			ST_VAR_GO: begin
				cmd.op = OP_VAR;
				cmd.div_start = 1'b1;
			end
			ST_VAR_WAIT: begin
				cmd.op = OP_VAR;
				cmd.cap = sts.div_done;
			end
			ST_WRITE:     cmd.write = 1'b1;
			ST_AVGM_GO: begin
				cmd.op = OP_AVGM;
				cmd.div_start = 1'b1;
			end
			ST_AVGM_WAIT: begin
				cmd.op = OP_AVGM;
				cmd.cap = sts.div_done;
			end
			ST_AVGV_GO: begin
				cmd.op = OP_AVGV;
				cmd.div_start = 1'b1;
			end
			ST_AVGV_WAIT: begin
				cmd.op = OP_AVGV;
				cmd.cap = sts.div_done;
			end
			ST_SQA_GO: begin
				cmd.op = OP_SQA;
				cmd.sqrt_start = 1'b1;
			end
			ST_SQA_WAIT: begin
				cmd.op = OP_SQA;
				cmd.cap = sts.sqrt_done;
			end
			ST_SQN_GO: begin
				cmd.op = OP_SQN;
				cmd.sqrt_start = 1'b1;
			end
			ST_SQN_WAIT: begin
				cmd.op = OP_SQN;
				cmd.cap = sts.sqrt_done;
			end
			ST_SQX_GO: begin
				cmd.op = OP_SQX;
				cmd.sqrt_start = 1'b1;
			end
			ST_SQX_WAIT: begin
				cmd.op = OP_SQX;
				cmd.cap = sts.sqrt_done;
			end
			ST_SEND:      cmd.send = sts.out_free;
			default:      cmd = '0;
		endcase
	end
endmodule

[rtl/prmv_dp.sv]
module prmv_dp #(
	parameter int FRAME_PIXELS = 65536,
	parameter int PIXEL_BITS   = 16,
	parameter int MAX_FRAMES   = 65535
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  prmv_pkg::ctrl_cmd_t         cmd,
	output prmv_pkg::ctrl_sts_t         sts,
	input  logic                        cfg_we,
	input  logic [prmv_pkg::WU_W-1:0]   cfg_data,
	input  logic                        in_kind,
	input  logic [prmv_pkg::PIX_W-1:0]  in_pixel,
	input  logic                        in_last,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [prmv_pkg::FC_W-1:0]   out_frames_used,
	output logic [prmv_pkg::PIX_W-1:0]  out_capture_min,
	output logic [prmv_pkg::PIX_W-1:0]  out_capture_max,
	output logic [prmv_pkg::MEAN_W-1:0] out_mean_average,
	output logic [prmv_pkg::MEAN_W-1:0] out_mean_min,
	output logic [prmv_pkg::MEAN_W-1:0] out_mean_max,
	output logic [prmv_pkg::MEAN_W-1:0] out_std_avg,
	output logic [prmv_pkg::MEAN_W-1:0] out_std_min,
	output logic [prmv_pkg::MEAN_W-1:0] out_std_max
);
	import prmv_pkg::*;

	localparam int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
	localparam logic [AW-1:0]    LAST_IDX  = AW'(FRAME_PIXELS - 1);
	localparam logic [PIX_W-1:0] PIX_MASK  = PIX_W'((32'h1 << PIXEL_BITS) - 1);
	localparam logic [FC_W-1:0]  FC_LIMIT  = FC_W'(MAX_FRAMES);

	logic [WU_W-1:0]   wf_q, warm_q;
	logic [FC_W-1:0]   fc_q;
	logic [AW-1:0]     idx_q;
	logic              inf_q;
	logic              kind_q, last_q;
	logic [PIX_W-1:0]  px_q;
	logic [MEAN_W-1:0] old_m_q, mag_q, m_q;
	logic [S_W-1:0]    old_s_q, s_q;
	logic              up_q;
	logic [PROD_W-1:0] prod_q;
	logic [VAR_W-1:0]  var_q;
	logic [PIX_W-1:0]  cmin_q, cmax_q;
	logic [MEAN_W-1:0] mmin_q, mmax_q;
	logic [VAR_W-1:0]  vmin_q, vmax_q;
	logic [SUM_W-1:0]  sum_m_q, sum_v_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [MEAN_W-1:0] avg_m_q, std_a_q, std_n_q, std_x_q;
	logic [VAR_W-1:0]  avg_v_q;
	logic              o_valid_q;

	logic [MEAN_W-1:0] x, ram_m;
	logic [S_W-1:0]    ram_s;
	logic [AW-1:0]     raddr;
	logic              warm_block;
	logic [NUM_W-1:0]  div_num, quo;
	logic [DEN_W-1:0]  div_den, rem;
	logic              div_done, sqrt_done;
	logic [VAR_W-1:0]  sq_val;
	logic [MEAN_W-1:0] root;
	logic [MEAN_W+1:0] sq_rem;
	logic [MEAN_W:0]   root_up;
	logic [MEAN_W-1:0] std_r;
	logic              rnd;
	logic [NUM_W:0]    quo_rnd;
	logic [MEAN_W:0]   m_sum;
	logic [S_W:0]      s_sum;
	logic [SUM_W:0]    sm_next, sv_next;

	assign x          = {px_q, 8'h00};
	assign warm_block = !inf_q && (warm_q < wf_q);
	assign raddr      = inf_q ? idx_q : '0;

	assign sts.skip      = kind_q || warm_block;
	assign sts.first     = fc_q <= FC_W'(1);
	assign sts.last      = last_q;
	assign sts.div_done  = div_done;
	assign sts.sqrt_done = sqrt_done;
	assign sts.out_free  = !o_valid_q || out_ready;

	prmv_ram #(.WIDTH(MEAN_W), .DEPTH(FRAME_PIXELS)) u_mean_ram (
		.clk(clk), .we(cmd.write), .waddr(idx_q), .wdata(m_q), .raddr(raddr), .rdata(ram_m)
	);
	prmv_ram #(.WIDTH(S_W), .DEPTH(FRAME_PIXELS)) u_dev_ram (
		.clk(clk), .we(cmd.write), .waddr(idx_q), .wdata(s_q), .raddr(raddr), .rdata(ram_s)
	);

	always_comb begin
		case (cmd.op)
			OP_STEP: begin
				div_num = NUM_W'({mag_q, 1'b0}) + NUM_W'(fc_q);
				div_den = DEN_W'({fc_q, 1'b0});
			end
			OP_VAR: begin
				div_num = NUM_W'(s_q);
				div_den = DEN_W'(fc_q - FC_W'(1));
			end
			OP_AVGM: begin
				div_num = sum_m_q;
				div_den = cnt_q;
			end
			default: begin
				div_num = sum_v_q;
				div_den = cnt_q;
			end
		endcase
		case (cmd.op)
			OP_SQN:  sq_val = vmin_q;
			OP_SQX:  sq_val = vmax_q;
			default: sq_val = avg_v_q;
		endcase
	end

	prmv_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .num(div_num), .den(div_den),
		.quo(quo), .rem(rem), .done(div_done)
	);
	prmv_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(cmd.sqrt_start), .value(sq_val),
		.root(root), .rem(sq_rem), .done(sqrt_done)
	);

	// Averages round half up: bump when twice the remainder reaches the count.
	assign rnd     = {rem, 1'b0} >= {1'b0, cnt_q};
	assign quo_rnd = {1'b0, quo} + (NUM_W+1)'(rnd);
	assign root_up = {1'b0, root} + (MEAN_W+1)'(sq_rem > (MEAN_W+2)'(root));
	assign std_r   = root_up[MEAN_W] ? MEAN_LIMIT : root_up[MEAN_W-1:0];

	assign m_sum   = up_q ? {1'b0, old_m_q} + quo[MEAN_W:0] : {1'b0, old_m_q} - quo[MEAN_W:0];
	assign s_sum   = {1'b0, old_s_q} + (S_W+1)'(prod_q);
	assign sm_next = {1'b0, sum_m_q} + (SUM_W+1)'(m_q);
	assign sv_next = {1'b0, sum_v_q} + (SUM_W+1)'(var_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wf_q      <= WARMUP_RESET;
			warm_q    <= '0;
			fc_q      <= '0;
			idx_q     <= '0;
			inf_q     <= 1'b0;
			kind_q    <= 1'b0;
			o_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				wf_q <= cfg_data;
			end
			if (cmd.grab) begin
				kind_q <= in_kind;
			end
			if (cmd.check) begin
				if (kind_q) begin
					fc_q <= '0;
				end else if (warm_block) begin
					if (last_q && warm_q != '1) begin
						warm_q <= warm_q + WU_W'(1);
					end
				end else if (!inf_q) begin
					if (fc_q < FC_LIMIT) begin
						fc_q <= fc_q + FC_W'(1);
					end
					inf_q <= 1'b1;
					idx_q <= '0;
				end
			end
			if (cmd.write) begin
				idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + AW'(1);
			end
			if (cmd.send) begin
				o_valid_q <= 1'b1;
				inf_q     <= 1'b0;
			end else if (out_ready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.grab) begin
			px_q   <= in_pixel & PIX_MASK;
			last_q <= in_last;
		end
		if (cmd.check && !kind_q && !warm_block && !inf_q) begin
			cmin_q  <= '1;
			cmax_q  <= '0;
			mmin_q  <= MEAN_LIMIT;
			mmax_q  <= '0;
			vmin_q  <= VAR_LIMIT;
			vmax_q  <= '0;
			sum_m_q <= '0;
			sum_v_q <= '0;
			cnt_q   <= '0;
		end
		if (cmd.rd) begin
			old_m_q <= ram_m;
			old_s_q <= ram_s;
			up_q    <= x >= ram_m;
			mag_q   <= (x >= ram_m) ? x - ram_m : ram_m - x;
			if (sts.first) begin
				m_q   <= x;
				s_q   <= '0;
				var_q <= '0;
			end
		end
		if (cmd.ld_mean) begin
			m_q <= m_sum[MEAN_W] ? MEAN_LIMIT : m_sum[MEAN_W-1:0];
		end
		if (cmd.ld_prod) begin
			prod_q <= mag_q * (up_q ? x - m_q : m_q - x);
		end
		if (cmd.ld_sadd) begin
			s_q <= s_sum[S_W] ? S_LIMIT : s_sum[S_W-1:0];
		end
		if (cmd.cap) begin
			case (cmd.op)
				OP_VAR:  var_q <= (quo > NUM_W'(VAR_LIMIT)) ? VAR_LIMIT : quo[VAR_W-1:0];
				OP_AVGM: avg_m_q <= (quo_rnd > (NUM_W+1)'(MEAN_LIMIT)) ?
					MEAN_LIMIT : quo_rnd[MEAN_W-1:0];
				OP_AVGV: avg_v_q <= (quo_rnd > (NUM_W+1)'(VAR_LIMIT)) ?
					VAR_LIMIT : quo_rnd[VAR_W-1:0];
				OP_SQA:  std_a_q <= std_r;
				OP_SQN:  std_n_q <= std_r;
				default: std_x_q <= std_r;
			endcase
		end
		if (cmd.write) begin
			if (px_q < cmin_q) cmin_q <= px_q;
			if (px_q > cmax_q) cmax_q <= px_q;
			if (m_q < mmin_q) mmin_q <= m_q;
			if (m_q > mmax_q) mmax_q <= m_q;
			if (var_q < vmin_q) vmin_q <= var_q;
			if (var_q > vmax_q) vmax_q <= var_q;
			sum_m_q <= sm_next[SUM_W] ? '1 : sm_next[SUM_W-1:0];
			sum_v_q <= sv_next[SUM_W] ? '1 : sv_next[SUM_W-1:0];
			if (cnt_q != '1) cnt_q <= cnt_q + CNT_W'(1);
		end
		if (cmd.send) begin
			out_frames_used  <= fc_q;
			out_capture_min  <= cmin_q;
			out_capture_max  <= cmax_q;
			out_mean_average <= avg_m_q;
			out_mean_min     <= mmin_q;
			out_mean_max     <= mmax_q;
			out_std_avg      <= std_a_q;
			out_std_min      <= std_n_q;
			out_std_max      <= std_x_q;
		end
	end

	assign out_valid = o_valid_q;
endmodule

[rtl/pixel_running_mean_variance.sv]
// A pixel in the first frame goes through check, read and write; a later pixel
// also takes two passes of the 64-step bit-serial divider. Restart and warmup
// items end after the check. The last pixel of a frame then adds two more
// divisions for the averages and three square roots, and waits for the result
// register to be free. The block takes no new item until it is through with the last.
// Reset (arst_n low, asynchronous) clears control state and the frame and warmup counters;
// the statistics registers and the per-pixel mean and deviation memories are not cleared and hold data once written.
module pixel_running_mean_variance #(
	parameter int FRAME_PIXELS = 65536,
	parameter int PIXEL_BITS   = 16,
	parameter int MAX_FRAMES   = 65535
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [prmv_pkg::WU_W-1:0] cfg_data,
	prmv_pix_if.sink                  pixels,
	prmv_res_if.source                results
);
	import prmv_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	assign pixels.ready = cmd.take;

	prmv_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(pixels.valid), .sts(sts), .cmd(cmd)
	);

	prmv_dp #(
		.FRAME_PIXELS(FRAME_PIXELS), .PIXEL_BITS(PIXEL_BITS), .MAX_FRAMES(MAX_FRAMES)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_kind(pixels.kind), .in_pixel(pixels.pixel), .in_last(pixels.last_in_frame),
		.out_ready(results.ready), .out_valid(results.valid),
		.out_frames_used(results.frames_used),
		.out_capture_min(results.capture_min), .out_capture_max(results.capture_max),
		.out_mean_average(results.mean_average),
		.out_mean_min(results.mean_min), .out_mean_max(results.mean_max),
		.out_std_avg(results.std_of_average_variance),
		.out_std_min(results.std_min), .out_std_max(results.std_max)
	);
endmodule

[rtl/prmv_checker.sv]
module prmv_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [prmv_pkg::PIX_W-1:0]  cap_min,
	input logic [prmv_pkg::PIX_W-1:0]  cap_max,
	input logic [prmv_pkg::MEAN_W-1:0] m_min,
	input logic [prmv_pkg::MEAN_W-1:0] m_max,
	input logic [prmv_pkg::MEAN_W-1:0] sd_min,
	input logic [prmv_pkg::MEAN_W-1:0] sd_max
);
	// A stalled result stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");

	// A result never becomes valid straight after an accepted item.
	a_no_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid)) else $error("result too soon");

	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cap_min <= cap_max) else $error("capture extremes inverted");

	a_mean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> m_min <= m_max) else $error("mean extremes inverted");

	a_std: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sd_min <= sd_max) else $error("deviation extremes inverted");
endmodule

bind pixel_running_mean_variance prmv_checker u_prmv_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(pixels.valid), .in_ready(pixels.ready),
	.out_valid(results.valid), .out_ready(results.ready),
	.cap_min(results.capture_min), .cap_max(results.capture_max),
	.m_min(results.mean_min), .m_max(results.mean_max),
	.sd_min(results.std_min), .sd_max(results.std_max)
);

[sim/tb_top.sv]
module tb_top;
	import prmv_pkg::*;

	typedef struct {
		logic [FC_W-1:0]   frames_used;
		logic [PIX_W-1:0]  capture_min;
		logic [PIX_W-1:0]  capture_max;
		logic [MEAN_W-1:0] mean_average;
		logic [MEAN_W-1:0] mean_min;
		logic [MEAN_W-1:0] mean_max;
		logic [MEAN_W-1:0] std_avg;
		logic [MEAN_W-1:0] std_min;
		logic [MEAN_W-1:0] std_max;
	} frame_report_t;

	localparam int LONGEST_FRAME = 8;
	localparam int QUIET_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 500;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [WU_W-1:0] cfg_data;

	prmv_pix_if pix ();
	prmv_res_if res ();

	pixel_running_mean_variance dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.pixels  (pix),
		.results (res)
	);

	// Predicted state of the statistics engine.
	logic [WU_W-1:0] warmup_limit;
	int unsigned warmup_count;
	int unsigned frames_n;
	bit frame_open;
	int unsigned pix_pos;
	longint unsigned pix_count;
	longint unsigned cap_lo, cap_hi, mean_lo, mean_hi, var_lo, var_hi;
	longint unsigned mean_sum, var_sum;
	longint unsigned mean_mem [int];
	longint unsigned dev_mem [int];

	frame_report_t reports_due [$];
	int fail_count;
	int items_sent;
	int quiet_cycles;
	int stall_ask;
	int stall_left;
	bit steady;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic longint unsigned div_nearest(longint unsigned num, longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = num / den;
		r = num - q * den;
		if (r >= den - r)
			q++;
		return q;
	endfunction

	function automatic longint unsigned root_nearest(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		longint unsigned rem;
		r = 0;
		b = 64'd1 << 62;
		rem = v;
		while (b > rem)
			b >>= 2;
		while (b != 0) begin
			if (rem >= r + b) begin
				rem -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		if (v - r * r > r)
			r++;
		return (r > MEAN_LIMIT) ? MEAN_LIMIT : r;
	endfunction

	// Applies one accepted item to the predicted state; the last pixel of a frame past warmup queues a report.
	function automatic void track_pixel(bit kind, logic [PIX_W-1:0] pixel, bit last);
		longint unsigned x, m, s, vr, old_m, mag, stp, prod, n, avg_m, avg_v;
		frame_report_t rep;
		if (kind) begin
			frames_n = 0;
			return;
		end
		if (!frame_open) begin
			if (warmup_count < warmup_limit) begin
				if (last && warmup_count < 15)
					warmup_count++;
				return;
			end
			if (frames_n < 65535)
				frames_n++;
			frame_open = 1;
			pix_pos = 0;
			pix_count = 0;
			cap_lo = 16'hFFFF;
			cap_hi = 0;
			mean_lo = MEAN_LIMIT;
			mean_hi = 0;
			var_lo = VAR_LIMIT;
			var_hi = 0;
			mean_sum = 0;
			var_sum = 0;
		end
		n = frames_n;
		x = longint'(pixel) << 8;
		if (n <= 1) begin
			m = x;
			s = 0;
			vr = 0;
		end else begin
			old_m = mean_mem[pix_pos];
			if (x >= old_m) begin
				mag = x - old_m;
				stp = (2 * mag + n) / (2 * n);
				m = old_m + stp;
				prod = mag * (x - m);
			end else begin
				mag = old_m - x;
				stp = (2 * mag + n) / (2 * n);
				m = old_m - stp;
				prod = mag * (m - x);
			end
			if (m > MEAN_LIMIT)
				m = MEAN_LIMIT;
			s = dev_mem[pix_pos];
			s = (S_LIMIT - s < prod) ? S_LIMIT : s + prod;
			vr = s / (n - 1);
			if (vr > VAR_LIMIT)
				vr = VAR_LIMIT;
		end
		mean_mem[pix_pos] = m;
		dev_mem[pix_pos] = s;
		if (pixel < cap_lo) cap_lo = pixel;
		if (pixel > cap_hi) cap_hi = pixel;
		if (m < mean_lo) mean_lo = m;
		if (m > mean_hi) mean_hi = m;
		if (vr < var_lo) var_lo = vr;
		if (vr > var_hi) var_hi = vr;
		mean_sum = (mean_sum + m < mean_sum) ? '1 : mean_sum + m;
		var_sum = (var_sum + vr < var_sum) ? '1 : var_sum + vr;
		pix_count++;
		pix_pos = (pix_pos + 1) % 65536;
		if (!last)
			return;
		avg_m = div_nearest(mean_sum, pix_count);
		avg_v = div_nearest(var_sum, pix_count);
		if (avg_m > MEAN_LIMIT) avg_m = MEAN_LIMIT;
		if (avg_v > VAR_LIMIT) avg_v = VAR_LIMIT;
		rep.frames_used = frames_n[FC_W-1:0];
		rep.capture_min = cap_lo[PIX_W-1:0];
		rep.capture_max = cap_hi[PIX_W-1:0];
		rep.mean_average = avg_m[MEAN_W-1:0];
		rep.mean_min = mean_lo[MEAN_W-1:0];
		rep.mean_max = mean_hi[MEAN_W-1:0];
		rep.std_avg = MEAN_W'(root_nearest(avg_v));
		rep.std_min = MEAN_W'(root_nearest(var_lo));
		rep.std_max = MEAN_W'(root_nearest(var_hi));
		reports_due.push_back(rep);
		frame_open = 0;
	endfunction

	task automatic send_item(bit kind, logic [PIX_W-1:0] pixel, bit last);
		if (!steady && $urandom_range(99) < 27) begin
			pix.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.kind <= kind;
		pix.pixel <= pixel;
		pix.last_in_frame <= last;
		@(posedge clk);
		while (!pix.ready)
			@(posedge clk);
		track_pixel(kind, pixel, last);
		items_sent++;
	endtask

	task automatic send_frame(int len, int mode);
		logic [PIX_W-1:0] base;
		logic [PIX_W-1:0] p;
		base = PIX_W'($urandom);
		for (int i = 0; i < len; i++) begin
			case (mode)
				0: p = PIX_W'($urandom);
				1: p = PIX_W'(base + $urandom_range(0, 3));
				2: p = $urandom_range(1) ? 16'hFFFF : 16'h0000;
				default: p = base;
			endcase
			send_item(1'b0, p, i == len - 1);
		end
	endtask

	// The block may still be busy on a frame that gives no report, so wait out its latency.
	task automatic wait_idle();
		pix.valid <= 1'b0;
		wait (reports_due.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_warmup(logic [WU_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_data <= v;
		warmup_limit = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic test_warmup_and_first();
		send_item(1'b0, 16'h1234, 1'b0);
		send_item(1'b1, 16'hFFFF, 1'b1);
		send_item(1'b0, 16'hFFFF, 1'b1);
		send_item(1'b0, 16'h0000, 1'b1);
		// The first used frame sets the longest frame that later frames may use.
		send_item(1'b0, 16'h0000, 1'b0);
		send_item(1'b0, 16'hFFFF, 1'b0);
		for (int i = 2; i < LONGEST_FRAME - 1; i++)
			send_item(1'b0, PIX_W'($urandom), 1'b0);
		send_item(1'b0, 16'h8000, 1'b1);
	endtask

	task automatic test_frames();
		for (int i = 0; i < LONGEST_FRAME; i++)
			send_item(1'b0, 16'hFFFF, i == LONGEST_FRAME - 1);
		for (int i = 0; i < LONGEST_FRAME; i++)
			send_item(1'b0, 16'h0000, i == LONGEST_FRAME - 1);
		send_item(1'b0, 16'h00FF, 1'b1);
		send_item(1'b1, 16'h0000, 1'b0);
		send_frame(3, 0);
		send_frame(4, 0);
		send_item(1'b0, 16'h4321, 1'b0);
		send_item(1'b1, 16'hABCD, 1'b1);
		send_item(1'b0, 16'h0001, 1'b1);
	endtask

	task automatic test_config();
		wait_idle();
		write_warmup(4'd0);
		send_frame(5, 1);
		wait_idle();
		write_warmup(4'd15);
		for (int i = 0; i < 14; i++)
			send_item(1'b0, PIX_W'($urandom), 1'b1);
		send_frame(6, 0);
		wait_idle();
		write_warmup(4'd2);
		send_frame(LONGEST_FRAME, 0);
	endtask

	// The receiver holds off long enough that a finished result stalls the block and later frames wait at its input.
	task automatic test_backpressure();
		wait_idle();
		stall_ask = 3000;
		for (int i = 0; i < 4; i++)
			send_frame($urandom_range(1, LONGEST_FRAME), 0);
	endtask

	task automatic test_random();
		int len;
		steady = 1'b1;
		while (items_sent < 850) begin
			if (items_sent > 300)
				steady = 1'b0;
			if ($urandom_range(99) < 6) begin
				send_item(1'b1, PIX_W'($urandom), 1'($urandom_range(1)));
			end else begin
				len = $urandom_range(1, LONGEST_FRAME);
				if ($urandom_range(99) < 5) begin
					send_item(1'b0, PIX_W'($urandom), 1'b0);
					send_item(1'b1, PIX_W'($urandom), 1'($urandom_range(1)));
					len = $urandom_range(1, LONGEST_FRAME - 1);
				end
				send_frame(len, $urandom_range(3));
			end
		end
		steady = 1'b0;
	endtask

	always @(posedge clk) begin
		if (stall_ask > 0) begin
			stall_left <= stall_ask;
			stall_ask = 0;
			res.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res.ready <= 1'b0;
		end else begin
			res.ready <= steady ? 1'b1 : ($urandom_range(99) >= 27);
		end
	end

	function automatic void check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		frame_report_t rep;
		if (res.valid && res.ready) begin
			if (reports_due.size() == 0) begin
				$error("report arrived with none expected");
				fail_count++;
			end else begin
				rep = reports_due.pop_front();
				check_field("frames_used", rep.frames_used, res.frames_used);
				check_field("capture_min", rep.capture_min, res.capture_min);
				check_field("capture_max", rep.capture_max, res.capture_max);
				check_field("mean_average", rep.mean_average, res.mean_average);
				check_field("mean_min", rep.mean_min, res.mean_min);
				check_field("mean_max", rep.mean_max, res.mean_max);
				check_field("std_of_average_variance", rep.std_avg,
					res.std_of_average_variance);
				check_field("std_min", rep.std_min, res.std_min);
				check_field("std_max", rep.std_max, res.std_max);
			end
		end
	end

	always @(posedge clk) begin
		if ((pix.valid && pix.ready) || (res.valid && res.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		pix.valid = 1'b0;
		pix.kind = 1'b0;
		pix.pixel = '0;
		pix.last_in_frame = 1'b0;
		res.ready = 1'b0;
		warmup_limit = WARMUP_RESET;
		warmup_count = 0;
		frames_n = 0;
		frame_open = 0;
		pix_pos = 0;
		pix_count = 0;
		fail_count = 0;
		items_sent = 0;
		quiet_cycles = 0;
		stall_ask = 0;
		stall_left = 0;
		steady = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_warmup_and_first();
		test_frames();
		test_config();
		test_backpressure();
		test_random();
		wait_idle();
		if (fail_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end
endmodule

[pixel_running_mean_variance.f]
rtl/prmv_pkg.sv
rtl/prmv_pix_if.sv
rtl/prmv_res_if.sv
rtl/prmv_ram.sv
rtl/prmv_div.sv
rtl/prmv_sqrt.sv
rtl/prmv_ctrl.sv
rtl/prmv_dp.sv
rtl/pixel_running_mean_variance.sv
rtl/prmv_checker.sv
sim/tb_top.sv
